// ===== rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, widths, codes and helpers of the least-squares line fit unit.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int SX_W  = 27;
  localparam int SXX_W = 42;
  localparam int CO_W  = 48;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // iterative divider widths
  localparam int DVD_W = 80;
  localparam int DSR_W = 52;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_FIT  = 2'd1;
  localparam logic [1:0] ACT_PRED = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PTS  = 2'd1;
  localparam logic [1:0] ST_X_EQUAL = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  localparam logic signed [CO_W-1:0] SAT_MAX = {1'b0, {(CO_W-1){1'b1}}};
  localparam logic signed [CO_W-1:0] SAT_MIN = {1'b1, {(CO_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [CO_W-1:0] slope;
    logic signed [CO_W-1:0] intercept;
    logic signed [CO_W-1:0] prediction;
  } out_item_t;

  // saturate a sign and magnitude quotient to the coefficient range
  function automatic logic signed [CO_W-1:0] sat_mag(input logic neg,
                                                     input logic [CO_W-1:0] mag,
                                                     input logic ovf);
    logic big;
    big = ovf | mag[CO_W-1];
    if (neg) begin
      sat_mag = big ? SAT_MIN : $signed(-mag);
    end else begin
      sat_mag = big ? SAT_MAX : $signed(mag);
    end
  endfunction

endpackage

// ===== rtl/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front
// Input stage: registers accepted words, drops unknown actions, feeds queue.
// ----------------------------------------------------------------------------
module lsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsf_pkg::in_item_t in_data,
  output logic              q_push,
  output lsf_pkg::in_item_t q_wdata,
  input  logic              q_ready
);

  logic              hv_r, hv_nxt;
  lsf_pkg::in_item_t hd_r;
  logic              accept;

  assign q_push   = hv_r && q_ready;
  assign in_ready = !hv_r || q_ready;
  assign accept   = in_valid && in_ready;
  assign q_wdata  = hd_r;

  always_comb begin
    if (accept) begin
      hv_nxt = (in_data.action != lsf_pkg::ACT_NONE);
    end else if (q_push) begin
      hv_nxt = 1'b0;
    end else begin
      hv_nxt = hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hd_r <= in_data;
    end
  end

endmodule

// ===== rtl/lsf_queue.sv =====
// ----------------------------------------------------------------------------
// lsf_queue
// Small register FIFO of decoded words between the front and the engine.
// ----------------------------------------------------------------------------
module lsf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lsf_pkg::in_item_t wdata,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output lsf_pkg::in_item_t rdata
);

  lsf_pkg::in_item_t          mem_r [lsf_pkg::Q_DEPTH];
  logic [lsf_pkg::Q_AW-1:0]   wr_r, rd_r;
  logic [lsf_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign valid   = (cnt_r != '0);
  assign ready   = (cnt_r != (lsf_pkg::Q_AW+1)'(lsf_pkg::Q_DEPTH));
  assign rdata   = mem_r[rd_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/lsf_div.sv =====
// ----------------------------------------------------------------------------
// lsf_div
// Restoring divider, one quotient bit per cycle, with saturation flag.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lsf_pkg::DVD_W-1:0]        dividend,
  input  logic [lsf_pkg::DSR_W-1:0]        divisor,
  output logic                             done,
  output logic [lsf_pkg::CO_W-1:0]         quo,
  output logic                             ovf
);

  logic [lsf_pkg::DVD_W-1:0]  dvd_r;
  logic [lsf_pkg::DSR_W-1:0]  dsr_r, rem_r;
  logic [lsf_pkg::CO_W-1:0]   q_r;
  logic                       ovf_r, busy_r, done_r;
  logic [lsf_pkg::DCNT_W-1:0] cnt_r;
  logic [lsf_pkg::DSR_W:0]    rem_s, diff;
  logic                       ge;

  assign rem_s = {rem_r, dvd_r[lsf_pkg::DVD_W-1]};
  assign diff  = rem_s - {1'b0, dsr_r};
  assign ge    = (rem_s >= {1'b0, dsr_r});
  assign done  = done_r;
  assign quo   = q_r;
  assign ovf   = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= lsf_pkg::DCNT_W'(lsf_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == lsf_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lsf_pkg::DVD_W-2:0], 1'b0};
      rem_r <= ge ? diff[lsf_pkg::DSR_W-1:0] : rem_s[lsf_pkg::DSR_W-1:0];
      q_r   <= {q_r[lsf_pkg::CO_W-2:0], ge};
      ovf_r <= ovf_r | q_r[lsf_pkg::CO_W-1];
    end
  end

endmodule

// ===== rtl/lsf_engine.sv =====
// ----------------------------------------------------------------------------
// lsf_engine
// Back end: accumulates samples, runs fit and predict, holds the result word.
// ----------------------------------------------------------------------------
module lsf_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lsf_pkg::in_item_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lsf_pkg::out_item_t out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRED = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_W    = 4'd7;
  localparam logic [3:0] S_ST2  = 4'd8;
  localparam logic [3:0] S_DIV2 = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  localparam int CW = lsf_pkg::CNT_W;
  localparam int XW = lsf_pkg::SX_W;
  localparam int QW = lsf_pkg::SXX_W;
  localparam int CO = lsf_pkg::CO_W;

  logic [3:0] st_r, st_nxt;

  // accumulators
  logic [CW-1:0]        n_r, n_nxt;
  logic signed [XW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [QW-1:0]        sxx_r, sxx_nxt;
  logic signed [QW-1:0] sxy_r, sxy_nxt;
  logic                 ovs_r, ovs_nxt;
  logic signed [CO-1:0] slope_r, slope_nxt, icpt_r, icpt_nxt;

  // working registers
  logic [1:0]           status_r, status_nxt;
  logic signed [CO-1:0] pred_r, pred_nxt;
  logic signed [63:0]   prod_r, prod_nxt;
  logic [52:0]          p_nsxx_r;
  logic signed [53:0]   p_sxsx_r, p_nsxy_r, p_sxsy_r;
  logic [51:0]          den_r;
  logic signed [54:0]   num_r;
  logic signed [62:0]   pl_r;
  logic signed [60:0]   ph_r;
  logic signed [76:0]   w_r;
  logic                 sgn_r, sgn_nxt;

  logic                 out_valid_r, out_valid_nxt;
  lsf_pkg::out_item_t   out_data_r;
  logic                 slot_free;

  logic                        div_start, div_done, div_ovf;
  logic [lsf_pkg::DVD_W-1:0]   div_dvd;
  logic [lsf_pkg::DSR_W-1:0]   div_dsr;
  logic [CO-1:0]               div_q;

  // combinational helpers
  logic signed [31:0]   xx, xy;
  logic [53:0]          den_full;
  logic [54:0]          num_mag;
  logic [76:0]          w_mag;
  logic signed [63:0]   shr;
  logic signed [55:0]   tq;
  logic signed [56:0]   psum;
  logic                 clr;

  lsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_q),
    .ovf      (div_ovf)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (st_r == S_IDLE) && q_valid;

  assign xx       = q_data.x_value * q_data.x_value;
  assign xy       = q_data.x_value * q_data.y_value;
  assign den_full = {1'b0, p_nsxx_r} - p_sxsx_r;
  assign num_mag  = num_r[54] ? 55'(-num_r) : num_r;
  assign w_mag    = w_r[76] ? 77'(-w_r) : w_r;
  assign shr      = prod_r >>> 8;
  assign tq       = shr[55:0] + 56'((prod_r[63] && (prod_r[7:0] != 8'd0)) ? 1 : 0);
  assign psum     = {tq[55], tq} + {{9{icpt_r[CO-1]}}, icpt_r};

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sxx_nxt       = sxx_r;
    sxy_nxt       = sxy_r;
    ovs_nxt       = ovs_r;
    slope_nxt     = slope_r;
    icpt_nxt      = icpt_r;
    status_nxt    = status_r;
    pred_nxt      = pred_r;
    prod_nxt      = prod_r;
    sgn_nxt       = sgn_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dsr       = '0;
    clr           = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_data.action)
            lsf_pkg::ACT_ADD: begin
              if (n_r >= CW'(lsf_pkg::MAX_POINTS)) begin
                ovs_nxt = 1'b1;
              end else begin
                n_nxt   = n_r + 1'b1;
                sx_nxt  = sx_r + XW'(q_data.x_value);
                sy_nxt  = sy_r + XW'(q_data.y_value);
                sxx_nxt = sxx_r + QW'($unsigned(xx));
                sxy_nxt = sxy_r + QW'(xy);
              end
            end
            lsf_pkg::ACT_PRED: begin
              prod_nxt = slope_r * q_data.x_value;
              st_nxt   = S_PRED;
            end
            lsf_pkg::ACT_FIT: begin
              pred_nxt = '0;
              if (ovs_r) begin
                status_nxt = lsf_pkg::ST_DROPPED;
                clr        = 1'b1;
                st_nxt     = S_EMIT;
              end else if (n_r == '0) begin
                status_nxt = lsf_pkg::ST_NO_PTS;
                clr        = 1'b1;
                st_nxt     = S_EMIT;
              end else if (n_r == CW'(1)) begin
                status_nxt = lsf_pkg::ST_OK;
                slope_nxt  = '0;
                icpt_nxt   = {{(CO-XW-8){sy_r[XW-1]}}, sy_r, 8'd0};
                clr        = 1'b1;
                st_nxt     = S_EMIT;
              end else begin
                st_nxt = S_MUL;
              end
            end
            default: begin
              // unknown action never reaches the queue
            end
          endcase
        end
      end
      S_PRED: begin
        status_nxt = lsf_pkg::ST_OK;
        if (psum > 57'(lsf_pkg::SAT_MAX)) begin
          pred_nxt = lsf_pkg::SAT_MAX;
        end else if (psum < 57'(lsf_pkg::SAT_MIN)) begin
          pred_nxt = lsf_pkg::SAT_MIN;
        end else begin
          pred_nxt = psum[CO-1:0];
        end
        st_nxt = S_EMIT;
      end
      S_MUL:  st_nxt = S_SUB;
      S_SUB:  st_nxt = S_CHK;
      S_CHK: begin
        if (den_r == '0) begin
          status_nxt = lsf_pkg::ST_X_EQUAL;
          clr        = 1'b1;
          st_nxt     = S_EMIT;
        end else begin
          div_start = 1'b1;
          div_dvd   = lsf_pkg::DVD_W'({num_mag, 16'd0});
          div_dsr   = lsf_pkg::DSR_W'(den_r);
          sgn_nxt   = num_r[54];
          st_nxt    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          slope_nxt = lsf_pkg::sat_mag(sgn_r, div_q, div_ovf);
          st_nxt    = S_MUL2;
        end
      end
      S_MUL2: st_nxt = S_W;
      S_W:    st_nxt = S_ST2;
      S_ST2: begin
        div_start = 1'b1;
        div_dvd   = lsf_pkg::DVD_W'(w_mag);
        div_dsr   = lsf_pkg::DSR_W'({n_r, 8'd0});
        sgn_nxt   = w_r[76];
        st_nxt    = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          icpt_nxt   = lsf_pkg::sat_mag(sgn_r, div_q, div_ovf);
          status_nxt = lsf_pkg::ST_OK;
          clr        = 1'b1;
          st_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (clr) begin
      n_nxt   = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sxx_nxt = '0;
      sxy_nxt = '0;
      ovs_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      n_r         <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      ovs_r       <= 1'b0;
      slope_r     <= '0;
      icpt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      n_r         <= n_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxx_r       <= sxx_nxt;
      sxy_r       <= sxy_nxt;
      ovs_r       <= ovs_nxt;
      slope_r     <= slope_nxt;
      icpt_r      <= icpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pred_r   <= pred_nxt;
    prod_r   <= prod_nxt;
    sgn_r    <= sgn_nxt;
    if (st_r == S_MUL) begin
      p_nsxx_r <= n_r * sxx_r;
      p_sxsx_r <= sx_r * sx_r;
      p_nsxy_r <= $signed({1'b0, n_r}) * sxy_r;
      p_sxsy_r <= sx_r * sy_r;
    end
    if (st_r == S_SUB) begin
      den_r <= den_full[51:0];
      num_r <= 55'(p_nsxy_r) - 55'(p_sxsy_r);
    end
    if (st_r == S_MUL2) begin
      pl_r <= slope_r * $signed({1'b0, sx_r[13:0]});
      ph_r <= slope_r * $signed(sx_r[XW-1:14]);
    end
    if (st_r == S_W) begin
      w_r <= {{34{sy_r[XW-1]}}, sy_r, 16'd0}
             - ({{2{ph_r[60]}}, ph_r, 14'd0} + {{14{pl_r[62]}}, pl_r});
    end
    if ((st_r == S_EMIT) && slot_free) begin
      out_data_r.status     <= status_r;
      out_data_r.slope      <= slope_r;
      out_data_r.intercept  <= icpt_r;
      out_data_r.prediction <= pred_r;
    end
  end

endmodule

// ===== rtl/least_squares_line_fit_unit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// Streaming least-squares straight-line fit with predict, Q32.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of words {action, x_value, y_value} in Q8.8.
//           Add sample accumulates and gives no result word; fit computes and
//           stores slope and intercept and clears the sums; predict returns
//           intercept + slope*x. Action code 3 is dropped at the input.
//   out_* : valid/ready channel of words {status, slope, intercept,
//           prediction}; a fit word carries prediction 0.
// Throughput and sequence:
//   Add samples stream at one word per cycle while the engine is idle: it
//   pops one queued word and updates all five sums in the same cycle; once
//   1024 samples are held, further adds only set the dropped flag.
//   Predict runs in the engine as multiply, round and saturate, output load.
//   A full-math fit runs through the shared restoring divider, which yields
//   one quotient bit per cycle, used twice (slope, then intercept) for 80
//   steps each; fits that end early (no points, one point, dropped samples)
//   go straight to output load. The input stage plus a 4-word queue keep
//   accepting words while the engine divides, until the queue fills.
// Reset (rst_n low, synchronous): clears the sums, count, coefficients and
//   all valid flags; no clearing pass is needed.
// Receiver stall: the result word holds in the output register; the engine
//   stops at its next result and the queue backs up to in_ready.
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lsf_pkg::out_item_t out_data
);

  logic              q_push, q_ready, q_valid, q_pop;
  lsf_pkg::in_item_t q_wdata, q_rdata;

  // classify and register incoming words
  lsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_ready  (q_ready)
  );

  // decouple front from engine so each can stall alone
  lsf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // accumulate, fit, predict and hold the result word
  lsf_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lsf_chk.sv =====
// ----------------------------------------------------------------------------
// lsf_chk
// Port-level checks of the line fit unit, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lsf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lsf_pkg::out_item_t out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // flagged fits carry no prediction
  a_flag_pred: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != lsf_pkg::ST_OK) |-> out_data.prediction == '0)
    else $error("flagged fit with nonzero prediction");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // a presented result word has every bit defined
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result word with unknown bits");

endmodule

bind least_squares_line_fit_unit lsf_chk u_lsf_chk (.*);
